### rtl/core/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg: shared definitions for the maximum-sum submatrix block
// Sizes, derived widths, register indexes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int MAX_ROWS      = 16;
  localparam int MAX_COLUMNS   = 16;
  localparam int ELEMENT_WIDTH = 16;

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_WIDTH = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  localparam int ROW_INDEX_WIDTH = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_INDEX_WIDTH = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_COUNT_WIDTH = $clog2(MAX_ROWS + 1);
  localparam int COL_COUNT_WIDTH = $clog2(MAX_COLUMNS + 1);

  localparam int SUM_WIDTH = ELEMENT_WIDTH + $clog2(CELL_COUNT) + 1;

  localparam int OUT_INDEX_WIDTH = 4;
  localparam int OUT_SUM_WIDTH   = 24;
  localparam int OUT_SUM_MAX     = 8388607;
  localparam int OUT_SUM_MIN     = -8388608;
  localparam int SAT_WIDTH = (SUM_WIDTH > OUT_SUM_WIDTH) ? SUM_WIDTH : OUT_SUM_WIDTH;

  localparam int CFG_WIDTH       = 5;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_RESET_SIZE  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COLUMN_COUNT = 1'b1;

  typedef logic signed [SUM_WIDTH-1:0]     sum_t;
  typedef logic [ADDR_WIDTH-1:0]           addr_t;
  typedef logic [ROW_INDEX_WIDTH-1:0]      row_idx_t;
  typedef logic [COL_INDEX_WIDTH-1:0]      col_idx_t;
  typedef logic [ROW_COUNT_WIDTH-1:0]      row_cnt_t;
  typedef logic [COL_COUNT_WIDTH-1:0]      col_cnt_t;
  typedef logic [CFG_WIDTH-1:0]            cfg_val_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } mss_state_t;

  function automatic row_cnt_t clamp_rows(input cfg_val_t v);
    row_cnt_t r;
    if (v == '0) begin
      r = row_cnt_t'(1);
    end else if (int'(v) > MAX_ROWS) begin
      r = row_cnt_t'(MAX_ROWS);
    end else begin
      r = row_cnt_t'(v);
    end
    return r;
  endfunction

  function automatic col_cnt_t clamp_cols(input cfg_val_t v);
    col_cnt_t r;
    if (v == '0) begin
      r = col_cnt_t'(1);
    end else if (int'(v) > MAX_COLUMNS) begin
      r = col_cnt_t'(MAX_COLUMNS);
    end else begin
      r = col_cnt_t'(v);
    end
    return r;
  endfunction

  function automatic logic signed [OUT_SUM_WIDTH-1:0] saturate_sum(input sum_t v);
    logic signed [SAT_WIDTH-1:0] x;
    logic signed [SAT_WIDTH-1:0] hi;
    logic signed [SAT_WIDTH-1:0] lo;
    x  = SAT_WIDTH'(v);
    hi = SAT_WIDTH'(OUT_SUM_MAX);
    lo = SAT_WIDTH'(OUT_SUM_MIN);
    if (x > hi) begin
      x = hi;
    end else if (x < lo) begin
      x = lo;
    end
    return x[OUT_SUM_WIDTH-1:0];
  endfunction

endpackage

### rtl/core/mss_ram.sv
// ----------------------------------------------------------------------------
// mss_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/max_sum_submatrix_top.sv
// ----------------------------------------------------------------------------
// max_sum_submatrix_top: maximum-sum submatrix search (two-dimensional Kadane)
// Loading takes one element per cycle, rows*columns transactions in all, while
// in_stall is low; it is high outside loading or while cfg_valid is asserted.
// The search then reads one stored element per cycle through a single adder
// path. Reset is synchronous: sizes return to 16 by 16 and loading restarts.
// ----------------------------------------------------------------------------
module max_sum_submatrix_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [mss_pkg::ELEMENT_WIDTH-1:0] in_element_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [mss_pkg::OUT_INDEX_WIDTH-1:0]     out_top_row,
  output logic [mss_pkg::OUT_INDEX_WIDTH-1:0]     out_left_column,
  output logic [mss_pkg::OUT_INDEX_WIDTH-1:0]     out_bottom_row,
  output logic [mss_pkg::OUT_INDEX_WIDTH-1:0]     out_right_column,
  output logic signed [mss_pkg::OUT_SUM_WIDTH-1:0] out_best_sum,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mss_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [mss_pkg::CFG_WIDTH-1:0]           cfg_data
);

  mss_pkg::mss_state_t state_r, state_nxt;

  mss_pkg::cfg_val_t rows_cfg_r, rows_cfg_nxt;
  mss_pkg::cfg_val_t cols_cfg_r, cols_cfg_nxt;
  mss_pkg::row_cnt_t rows_c, row_last_c;
  mss_pkg::col_cnt_t cols_c, col_last_c;

  mss_pkg::addr_t    ld_addr_r, ld_addr_nxt;
  mss_pkg::row_idx_t ld_row_r, ld_row_nxt;
  mss_pkg::col_idx_t ld_col_r, ld_col_nxt;

  mss_pkg::row_idx_t top_r, top_nxt;
  mss_pkg::row_idx_t bot_r, bot_nxt;
  mss_pkg::col_idx_t col_r, col_nxt;
  mss_pkg::addr_t    row_base_r, row_base_nxt;
  mss_pkg::addr_t    top_base_r, top_base_nxt;

  logic              p_valid_r, p_valid_nxt;
  mss_pkg::col_idx_t p_col_r, p_col_nxt;
  logic              p_first_r, p_first_nxt;
  logic              p_last_r, p_last_nxt;
  logic              p_fresh_r, p_fresh_nxt;
  mss_pkg::row_idx_t p_top_r, p_top_nxt;
  mss_pkg::row_idx_t p_bot_r, p_bot_nxt;

  logic              a_valid_r, a_valid_nxt;
  mss_pkg::col_idx_t a_col_r, a_col_nxt;
  logic              a_first_r, a_first_nxt;
  logic              a_last_r, a_last_nxt;
  mss_pkg::row_idx_t a_top_r, a_top_nxt;
  mss_pkg::row_idx_t a_bot_r, a_bot_nxt;
  mss_pkg::sum_t     a_sum_r, a_sum_nxt;

  mss_pkg::sum_t     colsum_r [mss_pkg::MAX_COLUMNS];

  mss_pkg::sum_t     run_r, run_nxt;
  mss_pkg::col_idx_t start_r, start_nxt;
  mss_pkg::sum_t     pair_best_r, pair_best_nxt;
  mss_pkg::col_idx_t pair_left_r, pair_left_nxt;
  mss_pkg::col_idx_t pair_right_r, pair_right_nxt;

  logic              c_valid_r, c_valid_nxt;
  mss_pkg::row_idx_t c_top_r, c_top_nxt;
  mss_pkg::row_idx_t c_bot_r, c_bot_nxt;

  logic              have_r, have_nxt;
  mss_pkg::sum_t     best_r, best_nxt;
  mss_pkg::row_idx_t best_top_r, best_top_nxt;
  mss_pkg::col_idx_t best_left_r, best_left_nxt;
  mss_pkg::row_idx_t best_bot_r, best_bot_nxt;
  mss_pkg::col_idx_t best_right_r, best_right_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [mss_pkg::OUT_INDEX_WIDTH-1:0] out_top_r, out_top_nxt;
  logic [mss_pkg::OUT_INDEX_WIDTH-1:0] out_left_r, out_left_nxt;
  logic [mss_pkg::OUT_INDEX_WIDTH-1:0] out_bot_r, out_bot_nxt;
  logic [mss_pkg::OUT_INDEX_WIDTH-1:0] out_right_r, out_right_nxt;
  logic signed [mss_pkg::OUT_SUM_WIDTH-1:0] out_sum_r, out_sum_nxt;

  logic in_accept;
  logic cfg_wr;
  logic out_load;
  logic ld_row_last, ld_col_last;
  logic col_is_last, bot_is_last, top_is_last;

  mss_pkg::addr_t ram_raddr;
  logic [mss_pkg::ELEMENT_WIDTH-1:0] ram_rdata;

  mss_pkg::sum_t elem_ext;
  mss_pkg::sum_t col_prev;
  mss_pkg::sum_t run_base;

  mss_ram #(
    .DATA_W (mss_pkg::ELEMENT_WIDTH),
    .DEPTH  (mss_pkg::CELL_COUNT),
    .ADDR_W (mss_pkg::ADDR_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (ld_addr_r),
    .wr_data (in_element_value),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rows_c     = mss_pkg::clamp_rows(rows_cfg_r);
  assign cols_c     = mss_pkg::clamp_cols(cols_cfg_r);
  assign row_last_c = rows_c - mss_pkg::row_cnt_t'(1);
  assign col_last_c = cols_c - mss_pkg::col_cnt_t'(1);

  assign in_stall  = (state_r != mss_pkg::ST_LOAD) || cfg_valid;
  assign cfg_ready = (state_r == mss_pkg::ST_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign ld_row_last = (mss_pkg::row_cnt_t'(ld_row_r) == row_last_c);
  assign ld_col_last = (mss_pkg::col_cnt_t'(ld_col_r) == col_last_c);
  assign col_is_last = (mss_pkg::col_cnt_t'(col_r) == col_last_c);
  assign bot_is_last = (mss_pkg::row_cnt_t'(bot_r) == row_last_c);
  assign top_is_last = (mss_pkg::row_cnt_t'(top_r) == row_last_c);

  assign ram_raddr = row_base_r + mss_pkg::addr_t'(col_r);

  always_comb begin
    state_nxt    = state_r;
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    ld_addr_nxt  = ld_addr_r;
    ld_row_nxt   = ld_row_r;
    ld_col_nxt   = ld_col_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    col_nxt      = col_r;
    row_base_nxt = row_base_r;
    top_base_nxt = top_base_r;
    out_load     = 1'b0;

    case (state_r)
      mss_pkg::ST_LOAD: begin
        if (cfg_wr) begin
          case (cfg_index)
            mss_pkg::CFG_ROW_COUNT:    rows_cfg_nxt = cfg_data;
            mss_pkg::CFG_COLUMN_COUNT: cols_cfg_nxt = cfg_data;
            default: ;
          endcase
          ld_addr_nxt = '0;
          ld_row_nxt  = '0;
          ld_col_nxt  = '0;
        end else if (in_accept) begin
          if (ld_row_last && ld_col_last) begin
            ld_addr_nxt  = '0;
            ld_row_nxt   = '0;
            ld_col_nxt   = '0;
            top_nxt      = '0;
            bot_nxt      = '0;
            col_nxt      = '0;
            row_base_nxt = '0;
            top_base_nxt = '0;
            state_nxt    = mss_pkg::ST_SCAN;
          end else begin
            ld_addr_nxt = ld_addr_r + mss_pkg::addr_t'(1);
            if (ld_col_last) begin
              ld_col_nxt = '0;
              ld_row_nxt = ld_row_r + mss_pkg::row_idx_t'(1);
            end else begin
              ld_col_nxt = ld_col_r + mss_pkg::col_idx_t'(1);
            end
          end
        end
      end
      mss_pkg::ST_SCAN: begin
        if (!col_is_last) begin
          col_nxt = col_r + mss_pkg::col_idx_t'(1);
        end else begin
          col_nxt = '0;
          if (!bot_is_last) begin
            bot_nxt      = bot_r + mss_pkg::row_idx_t'(1);
            row_base_nxt = row_base_r + mss_pkg::addr_t'(cols_c);
          end else if (!top_is_last) begin
            top_nxt      = top_r + mss_pkg::row_idx_t'(1);
            bot_nxt      = top_r + mss_pkg::row_idx_t'(1);
            top_base_nxt = top_base_r + mss_pkg::addr_t'(cols_c);
            row_base_nxt = top_base_r + mss_pkg::addr_t'(cols_c);
          end else begin
            state_nxt = mss_pkg::ST_DRAIN;
          end
        end
      end
      mss_pkg::ST_DRAIN: begin
        if (!p_valid_r && !a_valid_r && !c_valid_r) begin
          state_nxt = mss_pkg::ST_EMIT;
        end
      end
      mss_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = mss_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = mss_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    p_valid_nxt = (state_r == mss_pkg::ST_SCAN);
    p_col_nxt   = col_r;
    p_first_nxt = (col_r == '0);
    p_last_nxt  = col_is_last;
    p_fresh_nxt = (bot_r == top_r);
    p_top_nxt   = top_r;
    p_bot_nxt   = bot_r;

    elem_ext    = mss_pkg::sum_t'($signed(ram_rdata));
    col_prev    = p_fresh_r ? '0 : colsum_r[p_col_r];
    a_sum_nxt   = col_prev + elem_ext;
    a_valid_nxt = p_valid_r;
    a_col_nxt   = p_col_r;
    a_first_nxt = p_first_r;
    a_last_nxt  = p_last_r;
    a_top_nxt   = p_top_r;
    a_bot_nxt   = p_bot_r;

    run_nxt        = run_r;
    start_nxt      = start_r;
    pair_best_nxt  = pair_best_r;
    pair_left_nxt  = pair_left_r;
    pair_right_nxt = pair_right_r;
    run_base       = a_first_r ? '0 : run_r;
    if (a_valid_r) begin
      if (run_base[mss_pkg::SUM_WIDTH-1] || (run_base == '0)) begin
        run_nxt   = a_sum_r;
        start_nxt = a_col_r;
      end else begin
        run_nxt   = run_base + a_sum_r;
        start_nxt = start_r;
      end
      if (a_first_r || (pair_best_r <= run_nxt)) begin
        pair_best_nxt  = run_nxt;
        pair_left_nxt  = start_nxt;
        pair_right_nxt = a_col_r;
      end
    end
    c_valid_nxt = a_valid_r && a_last_r;
    c_top_nxt   = a_top_r;
    c_bot_nxt   = a_bot_r;

    have_nxt       = have_r;
    best_nxt       = best_r;
    best_top_nxt   = best_top_r;
    best_left_nxt  = best_left_r;
    best_bot_nxt   = best_bot_r;
    best_right_nxt = best_right_r;
    if ((state_r == mss_pkg::ST_LOAD) && (state_nxt == mss_pkg::ST_SCAN)) begin
      have_nxt = 1'b0;
    end else if (c_valid_r && (!have_r || (best_r < pair_best_r))) begin
      have_nxt       = 1'b1;
      best_nxt       = pair_best_r;
      best_top_nxt   = c_top_r;
      best_left_nxt  = pair_left_r;
      best_bot_nxt   = c_bot_r;
      best_right_nxt = pair_right_r;
    end

    out_top_nxt   = out_top_r;
    out_left_nxt  = out_left_r;
    out_bot_nxt   = out_bot_r;
    out_right_nxt = out_right_r;
    out_sum_nxt   = out_sum_r;
    if (out_load) begin
      out_top_nxt   = mss_pkg::OUT_INDEX_WIDTH'(best_top_r);
      out_left_nxt  = mss_pkg::OUT_INDEX_WIDTH'(best_left_r);
      out_bot_nxt   = mss_pkg::OUT_INDEX_WIDTH'(best_bot_r);
      out_right_nxt = mss_pkg::OUT_INDEX_WIDTH'(best_right_r);
      out_sum_nxt   = mss_pkg::saturate_sum(best_r);
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mss_pkg::ST_LOAD;
      rows_cfg_r  <= mss_pkg::CFG_WIDTH'(mss_pkg::CFG_RESET_SIZE);
      cols_cfg_r  <= mss_pkg::CFG_WIDTH'(mss_pkg::CFG_RESET_SIZE);
      ld_addr_r   <= '0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      top_r       <= '0;
      bot_r       <= '0;
      col_r       <= '0;
      row_base_r  <= '0;
      top_base_r  <= '0;
      p_valid_r   <= 1'b0;
      a_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_cfg_r  <= rows_cfg_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      ld_addr_r   <= ld_addr_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      col_r       <= col_nxt;
      row_base_r  <= row_base_nxt;
      top_base_r  <= top_base_nxt;
      p_valid_r   <= p_valid_nxt;
      a_valid_r   <= a_valid_nxt;
      c_valid_r   <= c_valid_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_col_r      <= p_col_nxt;
    p_first_r    <= p_first_nxt;
    p_last_r     <= p_last_nxt;
    p_fresh_r    <= p_fresh_nxt;
    p_top_r      <= p_top_nxt;
    p_bot_r      <= p_bot_nxt;
    a_col_r      <= a_col_nxt;
    a_first_r    <= a_first_nxt;
    a_last_r     <= a_last_nxt;
    a_top_r      <= a_top_nxt;
    a_bot_r      <= a_bot_nxt;
    a_sum_r      <= a_sum_nxt;
    run_r        <= run_nxt;
    start_r      <= start_nxt;
    pair_best_r  <= pair_best_nxt;
    pair_left_r  <= pair_left_nxt;
    pair_right_r <= pair_right_nxt;
    c_top_r      <= c_top_nxt;
    c_bot_r      <= c_bot_nxt;
    best_r       <= best_nxt;
    best_top_r   <= best_top_nxt;
    best_left_r  <= best_left_nxt;
    best_bot_r   <= best_bot_nxt;
    best_right_r <= best_right_nxt;
    out_top_r    <= out_top_nxt;
    out_left_r   <= out_left_nxt;
    out_bot_r    <= out_bot_nxt;
    out_right_r  <= out_right_nxt;
    out_sum_r    <= out_sum_nxt;
    if (p_valid_r) begin
      colsum_r[p_col_r] <= a_sum_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_top_row      = out_top_r;
  assign out_left_column  = out_left_r;
  assign out_bottom_row   = out_bot_r;
  assign out_right_column = out_right_r;
  assign out_best_sum     = out_sum_r;

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mss_pkg::ST_EMIT) |-> (!p_valid_r && !a_valid_r && !c_valid_r))
    else $error("Result emitted while the scan pipeline still holds data.");

  a_pair_close: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r |-> $past(a_valid_r && a_last_r))
    else $error("Row pair closed without its last column.");

  a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mss_pkg::ST_SCAN) |-> (top_r <= bot_r))
    else $error("Bottom row is above the top row.");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mss_pkg::ST_EMIT))
    else $error("Result raised outside the emit state.");

endmodule
